/* src/nbg_pkg.sv */
`timescale 1ns / 1ps
package nbg_pkg;

   localparam int MaxBodiesDefault = 64;

   // body memory word: mass, position x/y/z, velocity x/y/z
   localparam int BodyW = 224;
   // acceleration memory word: x/y/z, signed Q32.32 each
   localparam int AccW  = 192;

   localparam logic [31:0] TimeStepReset  = 32'd16777216;
   localparam logic [6:0]  BodyCountReset = 7'd2;
   localparam logic [31:0] GravityReset   = 32'd1260822;
   localparam logic [31:0] SofteningReset = 32'd655;

   localparam logic [2:0] CsrTimeStep  = 3'd0;
   localparam logic [2:0] CsrBodyCount = 3'd1;
   localparam logic [2:0] CsrGravity   = 3'd2;
   localparam logic [2:0] CsrSoftening = 3'd3;

   localparam logic ReqLoad    = 1'b0;
   localparam logic ReqAdvance = 1'b1;

   // multiplier result clamps
   localparam logic [1:0] LimU64 = 2'd0;
   localparam logic [1:0] LimS64 = 2'd1;
   localparam logic [1:0] Lim34  = 2'd2;

   // divide / root unit operations
   localparam logic OpDiv  = 1'b0;
   localparam logic OpSqrt = 1'b1;

   typedef struct packed {
      logic [31:0] time_step;
      logic [6:0]  body_count;
      logic [31:0] gravity_constant;
      logic [31:0] softening;
   } cfg_type;

   typedef struct packed {
      logic        go;
      logic [63:0] a;
      logic [63:0] b;
      logic [5:0]  sh;
      logic [1:0]  lim;
   } mul_req_type;

   typedef struct packed {
      logic        go;
      logic        op;
      logic [63:0] num;
      logic [63:0] den;
   } ds_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] res;
   } unit_rsp_type;

endpackage

/* src/nbg_req_if.sv */
`timescale 1ns / 1ps
interface nbg_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [5:0]         body_index;
   logic [31:0]        body_mass;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;

   modport source (output valid, req_type, body_index, body_mass,
                   pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
   modport sink   (input valid, req_type, body_index, body_mass,
                   pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

/* src/nbg_rsp_if.sv */
`timescale 1ns / 1ps
interface nbg_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         out_index;
   logic signed [31:0] new_pos_x;
   logic signed [31:0] new_pos_y;
   logic signed [31:0] new_pos_z;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   logic signed [31:0] new_vel_z;
   logic               last_body;

   modport source (output valid, out_index, new_pos_x, new_pos_y, new_pos_z,
                   new_vel_x, new_vel_y, new_vel_z, last_body, input ready);
   modport sink   (input valid, out_index, new_pos_x, new_pos_y, new_pos_z,
                   new_vel_x, new_vel_y, new_vel_z, last_body, output ready);
endinterface

/* src/nbg_mul.sv */
`timescale 1ns / 1ps
module nbg_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  nbg_pkg::mul_req_type  req,
   output nbg_pkg::unit_rsp_type rsp
);
   import nbg_pkg::*;

   logic         busy_ff, busy_in, fin_ff, fin_in, done_ff, done_in;
   logic [1:0]   cnt_ff, cnt_in, lim_ff, lim_in;
   logic [5:0]   sh_ff, sh_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic [127:0] prod_ff, prod_in;

   logic [31:0]  ah, bh;
   logic [63:0]  pp, lim_val;
   logic [127:0] pp_sh, quo;

   // 64x64 product from four 32x32 partial products, one a cycle, then shifted right and clamped
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      lim_in  = lim_ff;
      sh_in   = sh_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      res_in  = res_ff;
      prod_in = prod_ff;

      ah = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      bh = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp = ah * bh;
      case (cnt_ff)
         2'd0:    pp_sh = {64'd0, pp};
         2'd1:    pp_sh = {32'd0, pp, 32'd0};
         2'd2:    pp_sh = {32'd0, pp, 32'd0};
         default: pp_sh = {pp, 64'd0};
      endcase

      quo = prod_ff >> sh_ff;
      case (lim_ff)
         LimS64:  lim_val = 64'h7FFF_FFFF_FFFF_FFFF;
         Lim34:   lim_val = 64'h0000_0004_0000_0000;
         default: lim_val = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase

      if (req.go) begin
         a_in    = req.a;
         b_in    = req.b;
         sh_in   = req.sh;
         lim_in  = req.lim;
         prod_in = '0;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = prod_ff + pp_sh;
         cnt_in  = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         res_in  = ((|quo[127:64]) || (quo[63:0] > lim_val)) ? lim_val : quo[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      lim_ff  <= lim_in;
      sh_ff   <= sh_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      res_ff  <= res_in;
      prod_ff <= prod_in;
   end

   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;

endmodule

/* src/nbg_divsqrt.sv */
`timescale 1ns / 1ps
module nbg_divsqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  nbg_pkg::ds_req_type   req,
   output nbg_pkg::unit_rsp_type rsp
);
   import nbg_pkg::*;

   logic        busy_ff, busy_in, done_ff, done_in, op_ff, op_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in, acc_ff, acc_in, aux_ff, aux_in;

   logic [64:0] trial, trial_sub;
   logic [63:0] tsum;

   // restoring divide, one quotient bit a cycle; root, one result bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      aux_in  = aux_ff;

      trial     = {rem_ff, acc_ff[63]};
      trial_sub = trial - {1'b0, aux_ff};
      tsum      = acc_ff + aux_ff;

      if (req.go) begin
         op_in   = req.op;
         busy_in = 1'b1;
         if (req.op == OpSqrt) begin
            rem_in = req.num;
            acc_in = '0;
            aux_in = 64'h4000_0000_0000_0000;
            cnt_in = 6'd31;
         end else begin
            rem_in = '0;
            acc_in = req.num;
            aux_in = req.den;
            cnt_in = 6'd63;
         end
      end else if (busy_ff) begin
         case (op_ff)
            OpSqrt: begin
               if (rem_ff >= tsum) begin
                  rem_in = rem_ff - tsum;
                  acc_in = (acc_ff >> 1) + aux_ff;
               end else begin
                  acc_in = acc_ff >> 1;
               end
               aux_in = aux_ff >> 2;
            end
            default: begin
               if (trial >= {1'b0, aux_ff}) begin
                  rem_in = trial_sub[63:0];
                  acc_in = {acc_ff[62:0], 1'b1};
               end else begin
                  rem_in = trial[63:0];
                  acc_in = {acc_ff[62:0], 1'b0};
               end
            end
         endcase
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      aux_ff <= aux_in;
   end

   assign rsp.done = done_ff;
   assign rsp.res  = acc_ff;

endmodule

/* src/nbg_core.sv */
`timescale 1ns / 1ps
module nbg_core #(
   parameter int MAX_BODIES = nbg_pkg::MaxBodiesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nbg_pkg::cfg_type      cfg,
   nbg_req_if.sink               req_ch,
   nbg_rsp_if.source             rsp_ch,
   output nbg_pkg::mul_req_type  mul_req,
   input  nbg_pkg::unit_rsp_type mul_rsp,
   output nbg_pkg::ds_req_type   ds_req,
   input  nbg_pkg::unit_rsp_type ds_rsp
);
   import nbg_pkg::*;

   localparam int AW = $clog2(MAX_BODIES);
   localparam int CW = $clog2(MAX_BODIES + 1);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_ROW_RD   = 5'd1;
   localparam logic [4:0] S_ROW_LAT  = 5'd2;
   localparam logic [4:0] S_PAIR_RD  = 5'd3;
   localparam logic [4:0] S_PAIR_LAT = 5'd4;
   localparam logic [4:0] S_SQ       = 5'd5;
   localparam logic [4:0] S_ROOT     = 5'd6;
   localparam logic [4:0] S_Q        = 5'd7;
   localparam logic [4:0] S_DIV      = 5'd8;
   localparam logic [4:0] S_G        = 5'd9;
   localparam logic [4:0] S_CI       = 5'd10;
   localparam logic [4:0] S_CJ       = 5'd11;
   localparam logic [4:0] S_PAIR_WR  = 5'd12;
   localparam logic [4:0] S_ROW_WR   = 5'd13;
   localparam logic [4:0] S_UPD_RD   = 5'd14;
   localparam logic [4:0] S_UPD_LAT  = 5'd15;
   localparam logic [4:0] S_DV       = 5'd16;
   localparam logic [4:0] S_DP       = 5'd17;
   localparam logic [4:0] S_EMIT     = 5'd18;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] sum;
      sum = {a[63], a} + {b[63], b};
      if (sum[64] != sum[63])
         return sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return sum[63:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
      if (v > 42'sd2147483647)
         return 32'sh7FFF_FFFF;
      if (v < -42'sd2147483648)
         return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // memories
   logic [BodyW-1:0] body_mem [MAX_BODIES];
   logic [AccW-1:0]  acc_mem  [MAX_BODIES];
   logic [BodyW-1:0] body_rd_ff, body_wdata;
   logic [AccW-1:0]  acc_rd_ff, acc_wdata;
   logic [AW-1:0]    rd_addr, body_waddr, acc_waddr;
   logic             body_we, acc_we;

   // sequencer state
   logic [4:0]    state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, n_ff, n_in, n_calc, i_nx, j_nx;
   logic [1:0]    ax_ff, ax_in;
   logic          mul_go_ff, mul_go_in, ds_go_ff, ds_go_in;

   // working registers
   logic [31:0]        mass_i_ff, mass_i_in, mass_j_ff, mass_j_in;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] vel_in [3];
   logic [2:0]         dsign_ff, dsign_in;
   logic [31:0]        dmag_ff [3];
   logic [31:0]        dmag_in [3];
   logic signed [63:0] acc_i_ff [3];
   logic signed [63:0] acc_i_in [3];
   logic signed [63:0] acc_j_ff [3];
   logic signed [63:0] acc_j_in [3];
   logic [50:0]        s_ff, s_in;
   logic [63:0]        g_ff, g_in, k_ff, k_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in, last_ff, last_in;
   logic [5:0]         out_index_ff, out_index_in;
   logic signed [31:0] out_pos_ff [3];
   logic signed [31:0] out_pos_in [3];
   logic signed [31:0] out_vel_ff [3];
   logic signed [31:0] out_vel_in [3];

   logic               req_fire;
   logic signed [32:0] diff;
   logic signed [63:0] contrib;
   logic signed [41:0] delta, wide;
   logic [63:0]        amag;
   logic [31:0]        vmag;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign n_calc = (int'(cfg.body_count) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(cfg.body_count);
   assign i_nx   = i_ff + CW'(1);
   assign j_nx   = j_ff + CW'(1);
   assign amag   = acc_i_ff[ax_ff][63] ? (~acc_i_ff[ax_ff] + 64'd1) : acc_i_ff[ax_ff];
   assign vmag   = vel_ff[ax_ff][31] ? (~vel_ff[ax_ff] + 32'd1) : vel_ff[ax_ff];

   always_comb begin
      case (state_ff)
         S_ROW_RD: rd_addr = i_ff[AW-1:0];
         S_UPD_RD: rd_addr = i_ff[AW-1:0];
         default:  rd_addr = j_ff[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      body_rd_ff <= body_mem[rd_addr];
      if (body_we)
         body_mem[body_waddr] <= body_wdata;
   end

   always_ff @(posedge clock) begin
      acc_rd_ff <= acc_mem[rd_addr];
      if (acc_we)
         acc_mem[acc_waddr] <= acc_wdata;
   end

   // operands of the shared units follow the state
   always_comb begin
      mul_req.go  = mul_go_ff;
      mul_req.a   = '0;
      mul_req.b   = '0;
      mul_req.sh  = 6'd16;
      mul_req.lim = LimU64;
      case (state_ff)
         S_SQ: begin
            mul_req.a = {32'd0, dmag_ff[ax_ff]};
            mul_req.b = {32'd0, dmag_ff[ax_ff]};
         end
         S_Q: begin
            mul_req.a = {13'd0, s_ff};
            mul_req.b = g_ff;
         end
         S_G: begin
            mul_req.a   = k_ff;
            mul_req.b   = {32'd0, dmag_ff[ax_ff]};
            mul_req.sh  = 6'd32;
            mul_req.lim = LimS64;
         end
         S_CI: begin
            mul_req.a   = g_ff;
            mul_req.b   = {32'd0, mass_j_ff};
            mul_req.sh  = 6'd24;
            mul_req.lim = LimS64;
         end
         S_CJ: begin
            mul_req.a   = g_ff;
            mul_req.b   = {32'd0, mass_i_ff};
            mul_req.sh  = 6'd24;
            mul_req.lim = LimS64;
         end
         S_DV: begin
            mul_req.a   = amag;
            mul_req.b   = {32'd0, cfg.time_step};
            mul_req.sh  = 6'd40;
            mul_req.lim = Lim34;
         end
         S_DP: begin
            mul_req.a  = {32'd0, vmag};
            mul_req.b  = {32'd0, cfg.time_step};
            mul_req.sh = 6'd24;
         end
         default: ;
      endcase

      ds_req.go  = ds_go_ff;
      ds_req.op  = (state_ff == S_ROOT) ? OpSqrt : OpDiv;
      ds_req.den = k_ff;
      if (state_ff == S_ROOT)
         ds_req.num = (s_ff[50:48] == 3'd0) ? {s_ff[47:0], 16'd0} : {13'd0, s_ff};
      else
         ds_req.num = {cfg.gravity_constant, 32'd0};
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      ax_in        = ax_ff;
      mul_go_in    = 1'b0;
      ds_go_in     = 1'b0;
      mass_i_in    = mass_i_ff;
      mass_j_in    = mass_j_ff;
      dsign_in     = dsign_ff;
      s_in         = s_ff;
      g_in         = g_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      out_index_in = out_index_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      for (int a = 0; a < 3; a++) begin
         pos_in[a]     = pos_ff[a];
         vel_in[a]     = vel_ff[a];
         dmag_in[a]    = dmag_ff[a];
         acc_i_in[a]   = acc_i_ff[a];
         acc_j_in[a]   = acc_j_ff[a];
         out_pos_in[a] = out_pos_ff[a];
         out_vel_in[a] = out_vel_ff[a];
      end
      body_we    = 1'b0;
      body_waddr = i_ff[AW-1:0];
      body_wdata = {mass_i_ff, pos_ff[0], pos_ff[1], pos_ff[2],
                    vel_ff[0], vel_ff[1], vel_ff[2]};
      acc_we     = 1'b0;
      acc_waddr  = i_ff[AW-1:0];
      acc_wdata  = {acc_i_ff[0], acc_i_ff[1], acc_i_ff[2]};
      diff       = '0;
      contrib    = '0;
      delta      = '0;
      wide       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.req_type == ReqLoad) begin
                  if (int'(req_ch.body_index) < MAX_BODIES) begin
                     body_we    = 1'b1;
                     body_waddr = AW'(req_ch.body_index);
                     body_wdata = {req_ch.body_mass, req_ch.pos_x, req_ch.pos_y,
                                   req_ch.pos_z, req_ch.vel_x, req_ch.vel_y,
                                   req_ch.vel_z};
                  end
               end else if (n_calc != '0) begin
                  n_in     = n_calc;
                  i_in     = '0;
                  state_in = S_ROW_RD;
               end
            end
         end
         S_ROW_RD: state_in = S_ROW_LAT;
         S_ROW_LAT: begin
            mass_i_in = body_rd_ff[223:192];
            for (int a = 0; a < 3; a++) begin
               pos_in[a]   = body_rd_ff[191-32*a -: 32];
               acc_i_in[a] = '0;
            end
            j_in     = '0;
            state_in = (i_ff == '0) ? S_ROW_WR : S_PAIR_RD;
         end
         S_PAIR_RD: state_in = S_PAIR_LAT;
         S_PAIR_LAT: begin
            mass_j_in = body_rd_ff[223:192];
            for (int a = 0; a < 3; a++) begin
               diff = $signed({body_rd_ff[191-32*a], body_rd_ff[191-32*a -: 32]})
                      - $signed({pos_ff[a][31], pos_ff[a]});
               dsign_in[a] = diff[32];
               dmag_in[a]  = diff[32] ? 32'(-diff) : diff[31:0];
               acc_j_in[a] = acc_rd_ff[191-64*a -: 64];
            end
            s_in      = {19'd0, cfg.softening};
            ax_in     = 2'd0;
            mul_go_in = 1'b1;
            state_in  = S_SQ;
         end
         S_SQ: begin
            if (mul_rsp.done) begin
               s_in = s_ff + {3'd0, mul_rsp.res[47:0]};
               if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  ds_go_in = 1'b1;
                  state_in = S_ROOT;
               end else begin
                  ax_in     = ax_ff + 2'd1;
                  mul_go_in = 1'b1;
               end
            end
         end
         S_ROOT: begin
            if (ds_rsp.done) begin
               // large sums take the root of s itself, scaled up afterwards
               g_in      = (s_ff[50:48] == 3'd0) ? ds_rsp.res : {ds_rsp.res[55:0], 8'd0};
               mul_go_in = 1'b1;
               state_in  = S_Q;
            end
         end
         S_Q: begin
            if (mul_rsp.done) begin
               if (mul_rsp.res == '0) begin
                  // coincident bodies: pull saturates
                  k_in      = '1;
                  mul_go_in = 1'b1;
                  state_in  = S_G;
               end else begin
                  k_in     = mul_rsp.res;
                  ds_go_in = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (ds_rsp.done) begin
               k_in      = ds_rsp.res;
               mul_go_in = 1'b1;
               state_in  = S_G;
            end
         end
         S_G: begin
            if (mul_rsp.done) begin
               g_in      = mul_rsp.res;
               mul_go_in = 1'b1;
               state_in  = S_CI;
            end
         end
         S_CI: begin
            if (mul_rsp.done) begin
               contrib = mul_rsp.res;
               if (dsign_ff[ax_ff])
                  contrib = -contrib;
               acc_i_in[ax_ff] = sat_add64(acc_i_ff[ax_ff], contrib);
               mul_go_in       = 1'b1;
               state_in        = S_CJ;
            end
         end
         S_CJ: begin
            if (mul_rsp.done) begin
               contrib = mul_rsp.res;
               if (!dsign_ff[ax_ff])
                  contrib = -contrib;
               acc_j_in[ax_ff] = sat_add64(acc_j_ff[ax_ff], contrib);
               if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  state_in = S_PAIR_WR;
               end else begin
                  ax_in     = ax_ff + 2'd1;
                  mul_go_in = 1'b1;
                  state_in  = S_G;
               end
            end
         end
         S_PAIR_WR: begin
            acc_we    = 1'b1;
            acc_waddr = j_ff[AW-1:0];
            acc_wdata = {acc_j_ff[0], acc_j_ff[1], acc_j_ff[2]};
            j_in      = j_nx;
            state_in  = (j_nx == i_ff) ? S_ROW_WR : S_PAIR_RD;
         end
         S_ROW_WR: begin
            // row i is complete: its own sum goes to memory before any later row reads it
            acc_we = 1'b1;
            if (i_nx == n_ff) begin
               i_in     = '0;
               state_in = S_UPD_RD;
            end else begin
               i_in     = i_nx;
               state_in = S_ROW_RD;
            end
         end
         S_UPD_RD: state_in = S_UPD_LAT;
         S_UPD_LAT: begin
            mass_i_in = body_rd_ff[223:192];
            for (int a = 0; a < 3; a++) begin
               pos_in[a]   = body_rd_ff[191-32*a -: 32];
               vel_in[a]   = body_rd_ff[95-32*a -: 32];
               acc_i_in[a] = acc_rd_ff[191-64*a -: 64];
            end
            ax_in     = 2'd0;
            mul_go_in = 1'b1;
            state_in  = S_DV;
         end
         S_DV: begin
            if (mul_rsp.done) begin
               delta = {7'd0, mul_rsp.res[34:0]};
               if (acc_i_ff[ax_ff][63])
                  delta = -delta;
               wide          = {{10{vel_ff[ax_ff][31]}}, vel_ff[ax_ff]} + delta;
               vel_in[ax_ff] = sat32(wide);
               mul_go_in     = 1'b1;
               if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  state_in = S_DP;
               end else begin
                  ax_in = ax_ff + 2'd1;
               end
            end
         end
         S_DP: begin
            if (mul_rsp.done) begin
               delta = {1'b0, mul_rsp.res[40:0]};
               if (vel_ff[ax_ff][31])
                  delta = -delta;
               wide          = {{10{pos_ff[ax_ff][31]}}, pos_ff[ax_ff]} + delta;
               pos_in[ax_ff] = sat32(wide);
               if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  state_in = S_EMIT;
               end else begin
                  ax_in     = ax_ff + 2'd1;
                  mul_go_in = 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               body_we      = 1'b1;
               rsp_valid_in = 1'b1;
               out_index_in = 6'(i_ff);
               last_in      = (i_nx == n_ff);
               for (int a = 0; a < 3; a++) begin
                  out_pos_in[a] = pos_ff[a];
                  out_vel_in[a] = vel_ff[a];
               end
               if (i_nx == n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_nx;
                  state_in = S_UPD_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_go_ff    <= 1'b0;
         ds_go_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_go_ff    <= mul_go_in;
         ds_go_ff     <= ds_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      n_ff         <= n_in;
      ax_ff        <= ax_in;
      mass_i_ff    <= mass_i_in;
      mass_j_ff    <= mass_j_in;
      dsign_ff     <= dsign_in;
      s_ff         <= s_in;
      g_ff         <= g_in;
      k_ff         <= k_in;
      last_ff      <= last_in;
      out_index_ff <= out_index_in;
      for (int a = 0; a < 3; a++) begin
         pos_ff[a]     <= pos_in[a];
         vel_ff[a]     <= vel_in[a];
         dmag_ff[a]    <= dmag_in[a];
         acc_i_ff[a]   <= acc_i_in[a];
         acc_j_ff[a]   <= acc_j_in[a];
         out_pos_ff[a] <= out_pos_in[a];
         out_vel_ff[a] <= out_vel_in[a];
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_index = out_index_ff;
   assign rsp_ch.new_pos_x = out_pos_ff[0];
   assign rsp_ch.new_pos_y = out_pos_ff[1];
   assign rsp_ch.new_pos_z = out_pos_ff[2];
   assign rsp_ch.new_vel_x = out_vel_ff[0];
   assign rsp_ch.new_vel_y = out_vel_ff[1];
   assign rsp_ch.new_vel_z = out_vel_ff[2];
   assign rsp_ch.last_body = last_ff;

endmodule

/* src/nbody_gravity_step_top.sv */
`timescale 1ns / 1ps
// Channel   Dir   Handshake            Carries
// req_ch    in    valid/ready          load one body, or advance one step
// rsp_ch    out   valid/ready          one body state per item, last_body on the final one
// csr_*     in    csr_wr_en, no ready  time_step, body_count, gravity_constant, softening
//
// A load is written to body memory as it is accepted. An advance visits n*(n-1)/2 body pairs,
// then updates each body; the pair cost is set by the divider and root, which share one unit,
// and by the 64x64 multiplier that is built from 32x32 partial products.
// Reset is synchronous; the memories need no clearing, as every acceleration row is rewritten
// during the step before it is read. A stalled rsp_ch holds the sequencer only at the next result.
module nbody_gravity_step_top #(
   parameter int MAX_BODIES = nbg_pkg::MaxBodiesDefault
) (
   input  logic        clock,
   input  logic        reset,
   nbg_req_if.sink     req_ch,
   nbg_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import nbg_pkg::*;

   logic [31:0] time_step_ff, time_step_in, gravity_ff, gravity_in;
   logic [31:0] softening_ff, softening_in;
   logic [6:0]  body_count_ff, body_count_in;

   cfg_type      cfg;
   mul_req_type  mul_req;
   ds_req_type   ds_req;
   unit_rsp_type mul_rsp, ds_rsp;

   always_comb begin
      time_step_in  = time_step_ff;
      body_count_in = body_count_ff;
      gravity_in    = gravity_ff;
      softening_in  = softening_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CsrTimeStep:  time_step_in  = csr_wdata;
            CsrBodyCount: body_count_in = csr_wdata[6:0];
            CsrGravity:   gravity_in    = csr_wdata;
            CsrSoftening: softening_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff  <= TimeStepReset;
         body_count_ff <= BodyCountReset;
         gravity_ff    <= GravityReset;
         softening_ff  <= SofteningReset;
      end else begin
         time_step_ff  <= time_step_in;
         body_count_ff <= body_count_in;
         gravity_ff    <= gravity_in;
         softening_ff  <= softening_in;
      end
   end

   assign cfg.time_step        = time_step_ff;
   assign cfg.body_count       = body_count_ff;
   assign cfg.gravity_constant = gravity_ff;
   assign cfg.softening        = softening_ff;

   nbg_core #(.MAX_BODIES(MAX_BODIES)) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp),
      .ds_req  (ds_req),
      .ds_rsp  (ds_rsp)
   );

   nbg_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   nbg_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .req   (ds_req),
      .rsp   (ds_rsp)
   );

endmodule
